/* hw/rtl/radial_spotlight_luma_assert.svh */
// Assertion macros for the radial spotlight RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef RADIAL_SPOTLIGHT_LUMA_ASSERT_SVH
`define RADIAL_SPOTLIGHT_LUMA_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RSL_ASSERT_IMPL(lbl, clk_s, rstn_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RSL_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/rsl_pkg.sv */
// Shared constants and types for the radial spotlight luma block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rsl_pkg;

    // Width of the signed center registers
    localparam int CENTER_BITS  = 13;
    // Fraction bits kept on the distance
    localparam int DIST_FRAC    = 8;
    // Width of the configuration register index
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_COL = 1'b0,
        CFG_CENTER_ROW = 1'b1
    } cfg_idx_t;

    // Control that travels with each beat through the root chain
    typedef struct packed {
        logic vld;
        logic in_radius;
    } rsl_ctl_t;

endpackage

/* hw/rtl/rsl_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit per beat.
// Depends on rsl_pkg for the control struct.
`timescale 1ns / 1ps

module rsl_sqrt_cell #(
    parameter int NQ        = 16,
    parameter int LUMA_BITS = 16,
    localparam int TW       = NQ + 3,
    localparam int OPW      = 2 * NQ
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rsl_pkg::rsl_ctl_t     ctl_in,
    input  logic [TW-1:0]         rem_in,
    input  logic [NQ-1:0]         root_in,
    input  logic [OPW-1:0]        op_in,
    input  logic [LUMA_BITS-1:0]  luma_in,
    output rsl_pkg::rsl_ctl_t     ctl_out,
    output logic [TW-1:0]         rem_out,
    output logic [NQ-1:0]         root_out,
    output logic [OPW-1:0]        op_out,
    output logic [LUMA_BITS-1:0]  luma_out
);
    import rsl_pkg::*;

    rsl_ctl_t             ctl_reg;
    logic [TW-1:0]        rem_reg;
    logic [TW-1:0]        rem_next;
    logic [NQ-1:0]        root_reg;
    logic [NQ-1:0]        root_next;
    logic [OPW-1:0]       op_reg;
    logic [LUMA_BITS-1:0] luma_reg;
    logic [TW-1:0]        rem_sh;
    logic [TW-1:0]        trial;
    logic                 ge;

    // Bring down the next two operand bits and try root bit one
    always_comb
    begin
        rem_sh    = {rem_in[TW-3:0], op_in[OPW-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[NQ-2:0], ge};
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            op_reg   <= {op_in[OPW-3:0], 2'b00};
            luma_reg <= luma_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign op_out   = op_reg;
    assign luma_out = luma_reg;

endmodule

/* hw/rtl/rsl_scale.sv */
// Scales luminance by the linear falloff factor: multiply, then divide by a
// constant through a reciprocal with one correction step. Depends on rsl_pkg.
`timescale 1ns / 1ps

module rsl_scale #(
    parameter int LUMA_BITS   = 16,
    parameter int SPOT_RADIUS = 200,
    localparam int NQ         = $clog2((SPOT_RADIUS << rsl_pkg::DIST_FRAC) + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  rsl_pkg::rsl_ctl_t     ctl_in,
    input  logic [NQ-1:0]         dq,
    input  logic [LUMA_BITS-1:0]  luma_in,
    output logic                  res_vld,
    output logic [LUMA_BITS-1:0]  res
);
    import rsl_pkg::*;

    localparam int FULL = SPOT_RADIUS << DIST_FRAC;
    localparam int PW   = LUMA_BITS + NQ;
    localparam int QW   = PW - DIST_FRAC;
    localparam longint unsigned RECIP = (longint'(1) << QW) / SPOT_RADIUS;
    localparam int RCW  = $clog2(RECIP + 1);
    localparam int RBW  = $clog2(SPOT_RADIUS + 1);
    localparam logic [RCW-1:0] RECIP_V  = RCW'(RECIP);
    localparam logic [RBW-1:0] RADIUS_V = RBW'(SPOT_RADIUS);

    logic                     vld_a_reg;
    logic                     vld_b_reg;
    logic                     vld_c_reg;
    logic                     vld_d_reg;
    logic [NQ-1:0]            fac;
    logic [PW-1:0]            prod_next;
    logic [PW-1:0]            prod_reg;
    logic [QW-1:0]            q_b;
    logic [QW+RCW-1:0]        recip_prod;
    logic [QW-1:0]            q_b_reg;
    logic [LUMA_BITS-1:0]     est_b_reg;
    logic [QW-1:0]            q_c_reg;
    logic [LUMA_BITS-1:0]     est_c_reg;
    logic [LUMA_BITS+RBW-1:0] estr_next;
    logic [LUMA_BITS+RBW-1:0] estr_reg;
    logic [QW-1:0]            rem_c;
    logic [LUMA_BITS-1:0]     res_next;
    logic [LUMA_BITS-1:0]     res_reg;

    // Form the factor, zero beyond the radius, and the product
    always_comb
    begin
        fac       = ctl_in.in_radius ? (NQ'(FULL) - dq) : '0;
        prod_next = {{NQ{1'b0}}, luma_in} * {{LUMA_BITS{1'b0}}, fac};
    end

    // Estimate the quotient by the reciprocal; low by at most one
    always_comb
    begin
        q_b        = prod_reg[PW-1:DIST_FRAC];
        recip_prod = {{RCW{1'b0}}, q_b} * {{QW{1'b0}}, RECIP_V};
        estr_next  = {{RBW{1'b0}}, est_b_reg} * {{LUMA_BITS{1'b0}}, RADIUS_V};
    end

    // Correct the estimate from the remainder
    always_comb
    begin
        rem_c    = q_c_reg - QW'(estr_reg);
        res_next = (rem_c >= QW'(SPOT_RADIUS)) ? (est_c_reg + 1'b1) : est_c_reg;
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= ctl_in.vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    // Advance stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            q_b_reg   <= q_b;
            est_b_reg <= recip_prod[QW +: LUMA_BITS];
            q_c_reg   <= q_b_reg;
            est_c_reg <= est_b_reg;
            estr_reg  <= estr_next;
            res_reg   <= res_next;
        end
    end

    assign res_vld = vld_d_reg;
    assign res     = res_reg;

endmodule

/* hw/rtl/rsl_out_buf.sv */
// Output register with a one-beat skid stage; raises the pipeline advance.
// Depends on rsl_pkg and the assertion macro header.
`timescale 1ns / 1ps

`include "radial_spotlight_luma_assert.svh"

module rsl_out_buf #(
    parameter int LUMA_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  d_vld,
    input  logic [LUMA_BITS-1:0]  d_data,
    output logic                  en,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LUMA_BITS-1:0]  luma_out
);
    import rsl_pkg::*;

    logic                 out_vld_reg;
    logic [LUMA_BITS-1:0] out_data_reg;
    logic                 skid_vld_reg;
    logic [LUMA_BITS-1:0] skid_data_reg;
    logic                 push;
    logic                 take;
    logic                 hold_push;
    logic                 drain_last;
    logic                 unload;

    // Pipeline moves only while the skid stage is empty
    assign en   = !skid_vld_reg;
    assign push = d_vld && !skid_vld_reg;
    assign take = out_vld_reg && out_ready;

    // Conditions watched by the checks below
    assign hold_push  = out_vld_reg && !out_ready && push;
    assign drain_last = take && !skid_vld_reg && !push;
    assign unload     = take && skid_vld_reg;

    // Update occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_vld_reg)
            begin
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= push;
            end
        end
        else if (!out_vld_reg)
        begin
            out_vld_reg <= push;
        end
        else if (push)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    // Move payload
    always_ff @(posedge clk)
    begin
        if (take && skid_vld_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (take || !out_vld_reg)
        begin
            out_data_reg <= d_data;
        end
        else if (push)
        begin
            skid_data_reg <= d_data;
        end
    end

    assign out_valid = out_vld_reg;
    assign luma_out  = out_data_reg;

    `RSL_ASSERT_IMPL(a_skid_needs_out, clk, rst_n, skid_vld_reg, out_vld_reg, "orphan skid beat")
    `RSL_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, hold_push, skid_vld_reg, "stalled beat lost")
    `RSL_ASSERT_NEXT(a_drain_empties, clk, rst_n, drain_last, !out_vld_reg, "output still valid")
    `RSL_ASSERT_NEXT(a_skid_up, clk, rst_n, unload, out_vld_reg && !skid_vld_reg, "skid not moved")

endmodule

/* hw/rtl/radial_spotlight_luma.sv */
// Radial spotlight: one luma beat in per cycle while in_ready is high, one
// dimmed luma beat out per input beat. Each result passes the front stages, the
// NQ cells of the square root chain and the scale stages, where NQ =
// clog2(256 * SPOT_RADIUS + 1), one root bit per cell. Downstream stalls are
// absorbed by a one-beat skid stage; in_ready falls only while that stage is
// full. The user must write the center registers through cfg_we / cfg_index /
// cfg_data only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module radial_spotlight_luma #(
    parameter int COORD_BITS  = 12,
    parameter int LUMA_BITS   = 16,
    parameter int SPOT_RADIUS = 200
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rsl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rsl_pkg::CENTER_BITS-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [COORD_BITS-1:0]               pixel_col,
    input  logic [COORD_BITS-1:0]               pixel_row,
    input  logic [LUMA_BITS-1:0]                luma_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [LUMA_BITS-1:0]                luma_out
);
    import rsl_pkg::*;

    localparam int DXW  = ((COORD_BITS > CENTER_BITS - 1) ? COORD_BITS : CENTER_BITS - 1) + 1;
    localparam int SW   = DXW + 1;
    localparam int SQW  = 2 * DXW;
    localparam int SUMW = SQW + 1;
    localparam longint unsigned RSQ = longint'(SPOT_RADIUS) * SPOT_RADIUS;
    localparam int NQ   = $clog2((SPOT_RADIUS << DIST_FRAC) + 1);
    localparam int TW   = NQ + 3;
    localparam int OPW  = 2 * NQ;

    logic signed [CENTER_BITS-1:0] center_col_reg;
    logic signed [CENTER_BITS-1:0] center_row_reg;
    logic                          en;

    logic signed [SW-1:0] col_diff;
    logic signed [SW-1:0] row_diff;
    logic [SW-1:0]        col_mag;
    logic [SW-1:0]        row_mag;

    logic                 vld0_reg;
    logic [DXW-1:0]       dx_reg;
    logic [DXW-1:0]       dy_reg;
    logic [LUMA_BITS-1:0] luma0_reg;

    logic                 vld1_reg;
    logic [SQW-1:0]       sqx_reg;
    logic [SQW-1:0]       sqy_reg;
    logic [SQW-1:0]       sqx_next;
    logic [SQW-1:0]       sqy_next;
    logic [LUMA_BITS-1:0] luma1_reg;

    logic [SUMW-1:0]      sumsq;
    logic [SUMW+2*DIST_FRAC-1:0] op_wide;
    rsl_ctl_t             ctl2_reg;
    logic [OPW-1:0]       op_reg;
    logic [LUMA_BITS-1:0] luma2_reg;

    rsl_ctl_t             ctl_w  [0:NQ];
    logic [TW-1:0]        rem_w  [0:NQ];
    logic [NQ-1:0]        root_w [0:NQ];
    logic [OPW-1:0]       op_w   [0:NQ];
    logic [LUMA_BITS-1:0] luma_w [0:NQ];

    logic                 res_vld;
    logic [LUMA_BITS-1:0] res;

    // Write center registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_COL: center_col_reg <= cfg_data;
                CFG_CENTER_ROW: center_row_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = en;

    // Take absolute distances to the center
    always_comb
    begin
        col_diff = $signed({{(SW-COORD_BITS){1'b0}}, pixel_col})
                 - $signed({{(SW-CENTER_BITS){center_col_reg[CENTER_BITS-1]}}, center_col_reg});
        row_diff = $signed({{(SW-COORD_BITS){1'b0}}, pixel_row})
                 - $signed({{(SW-CENTER_BITS){center_row_reg[CENTER_BITS-1]}}, center_row_reg});
        col_mag  = col_diff[SW-1] ? (~col_diff + 1'b1) : col_diff;
        row_mag  = row_diff[SW-1] ? (~row_diff + 1'b1) : row_diff;
    end

    // Square each distance
    always_comb
    begin
        sqx_next = {{DXW{1'b0}}, dx_reg} * {{DXW{1'b0}}, dx_reg};
        sqy_next = {{DXW{1'b0}}, dy_reg} * {{DXW{1'b0}}, dy_reg};
    end

    // Sum squares and scale for the fraction bits of the root
    always_comb
    begin
        sumsq   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        op_wide = {sumsq, {(2*DIST_FRAC){1'b0}}};
    end

    // Advance front stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            vld0_reg           <= in_valid;
            vld1_reg           <= vld0_reg;
            ctl2_reg.vld       <= vld1_reg;
            ctl2_reg.in_radius <= (sumsq <= SUMW'(RSQ));
        end
    end

    // Advance front stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= col_mag[DXW-1:0];
            dy_reg    <= row_mag[DXW-1:0];
            luma0_reg <= luma_in;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            luma1_reg <= luma0_reg;
            op_reg    <= OPW'(op_wide);
            luma2_reg <= luma1_reg;
        end
    end

    // Feed the root chain
    assign ctl_w[0]  = ctl2_reg;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign op_w[0]   = op_reg;
    assign luma_w[0] = luma2_reg;

    // Chain of root cells, one root bit each
    for (genvar k = 0; k < NQ; k++)
    begin : g_cell
        rsl_sqrt_cell #(
            .NQ        (NQ),
            .LUMA_BITS (LUMA_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (ctl_w[k]),
            .rem_in   (rem_w[k]),
            .root_in  (root_w[k]),
            .op_in    (op_w[k]),
            .luma_in  (luma_w[k]),
            .ctl_out  (ctl_w[k+1]),
            .rem_out  (rem_w[k+1]),
            .root_out (root_w[k+1]),
            .op_out   (op_w[k+1]),
            .luma_out (luma_w[k+1])
        );
    end

    // Apply the falloff
    rsl_scale #(
        .LUMA_BITS   (LUMA_BITS),
        .SPOT_RADIUS (SPOT_RADIUS)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_w[NQ]),
        .dq      (root_w[NQ]),
        .luma_in (luma_w[NQ]),
        .res_vld (res_vld),
        .res     (res)
    );

    // Hold results for the consumer
    rsl_out_buf #(
        .LUMA_BITS (LUMA_BITS)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .d_vld     (res_vld),
        .d_data    (res),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .luma_out  (luma_out)
    );

endmodule

/* verif/radial_spotlight_luma_test.sv */
// Self-checking testbench for radial_spotlight_luma: drives pixel beats under random
// sender gaps and receiver stalls and checks each dimmed luma against a local predictor.
// Depends on rsl_pkg and the radial_spotlight_luma RTL only.
`timescale 1ns / 1ps

module radial_spotlight_luma_test;
    import rsl_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int LUMA_BITS    = 16;
    localparam int SPOT_RADIUS  = 200;
    localparam int LATENCY      = 16 + 7;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_BEATS  = 190;
    localparam int MAX_MSGS     = 40;

    typedef struct {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [LUMA_BITS-1:0]  luma;
    } pixel_beat_t;

    typedef struct {
        pixel_beat_t          pix;
        logic [LUMA_BITS-1:0] luma;
    } luma_want_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_idx_t              cfg_index = CFG_CENTER_COL;
    logic [CENTER_BITS-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [COORD_BITS-1:0] pixel_col = '0;
    logic [COORD_BITS-1:0] pixel_row = '0;
    logic [LUMA_BITS-1:0]  luma_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [LUMA_BITS-1:0]  luma_out;

    pixel_beat_t pixel_pending[$];
    luma_want_t  luma_expected[$];
    int          center_col_q = 0;
    int          center_row_q = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    logic        hold_sender = 1'b0;

    radial_spotlight_luma #(
        .COORD_BITS  (COORD_BITS),
        .LUMA_BITS   (LUMA_BITS),
        .SPOT_RADIUS (SPOT_RADIUS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .luma_in   (luma_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .luma_out  (luma_out)
    );

    // Toggle the clock every half period
    always #10 clk = ~clk;

    // Dim one pixel: linear falloff over the radius, distance floored to 8 fraction bits
    function automatic logic [LUMA_BITS-1:0] predict_luma(pixel_beat_t pix);
        longint dx;
        longint dy;
        longint sumsq;
        longint scaled;
        longint root;
        longint trial;
        longint full;
        dx = longint'(pix.col) - center_col_q;
        dy = longint'(pix.row) - center_row_q;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        sumsq = dx * dx + dy * dy;
        if (sumsq > longint'(SPOT_RADIUS) * SPOT_RADIUS)
            return '0;
        full = longint'(SPOT_RADIUS) << DIST_FRAC;
        scaled = sumsq << (2 * DIST_FRAC);
        root = 0;
        for (int b = 24; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= scaled)
                root = trial;
        end
        if (root > full)
            root = full;
        return LUMA_BITS'((longint'(pix.luma) * (full - root)) / full);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_MSGS)
            $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Drive pixel beats in bursts with random gaps; hold payload until accepted
    always @(posedge clk)
    begin
        pixel_beat_t nxt;
        bit          took;
        static int   burst_left = 1;
        static int   gap_left = 0;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            took = in_valid && in_ready;
            if (!in_valid || took)
            begin
                if (gap_left > 0 || hold_sender || pixel_pending.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = pixel_pending.pop_front();
                    in_valid  <= 1'b1;
                    pixel_col <= nxt.col;
                    pixel_row <= nxt.row;
                    luma_in   <= nxt.luma;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 19))
                            0, 1, 2, 3, 4, 5: gap_left = 0;
                            19:               gap_left = $urandom_range(10, 30);
                            default:          gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
            end
        end
    end

    // Stall the receiver on a pattern that changes mode every so often
    always @(posedge clk)
    begin
        static int          stall_left = 0;
        static int          stall_mode = 0;
        static logic [15:0] stall_mask = '1;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
            stall_mask = $urandom;
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= stall_mask[stall_left % 16];
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Record each accepted pixel beat, then check each accepted result beat
    always @(posedge clk)
    begin
        pixel_beat_t pix;
        luma_want_t  want;
        if (rst_n && in_valid && in_ready)
        begin
            pix.col  = pixel_col;
            pix.row  = pixel_row;
            pix.luma = luma_in;
            want.pix  = pix;
            want.luma = predict_luma(pix);
            luma_expected.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (luma_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat luma_out=%0d", luma_out));
            end
            else
            begin
                want = luma_expected.pop_front();
                if (luma_out !== want.luma)
                    report_mismatch($sformatf(
                        "col=%0d row=%0d luma_in=%0d center=(%0d,%0d): luma_out=%0d want %0d",
                        want.pix.col, want.pix.row, want.pix.luma, center_col_q,
                        center_row_q, luma_out, want.luma));
            end
        end
    end

    // End the run if the block hangs
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_pixel(int col, int row, int luma);
        pixel_beat_t pix;
        pix.col  = COORD_BITS'(col);
        pix.row  = COORD_BITS'(row);
        pix.luma = LUMA_BITS'(luma);
        pixel_pending.push_back(pix);
    endtask

    // Wait until every pending beat is sent and every result has come back
    task automatic wait_drained();
        while (pixel_pending.size() != 0 || in_valid || luma_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_center(int col, int row);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CENTER_COL;
        cfg_data  <= CENTER_BITS'(col);
        @(posedge clk);
        cfg_index <= CFG_CENTER_ROW;
        cfg_data  <= CENTER_BITS'(row);
        @(posedge clk);
        cfg_we <= 1'b0;
        center_col_q = col;
        center_row_q = row;
        @(negedge clk);
    endtask

    function automatic int pick_luma();
        case ($urandom_range(0, 9))
            0:       return 65535;
            1:       return 0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // Mostly pixels around the center so the falloff is exercised, some anywhere
    task automatic push_random_pixel();
        if ($urandom_range(0, 3) != 0)
            push_pixel(clamp_coord(center_col_q + $urandom_range(0, 440) - 220),
                       clamp_coord(center_row_q + $urandom_range(0, 440) - 220),
                       pick_luma());
        else
            push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535));
    endtask

    function automatic int pick_center();
        if ($urandom_range(0, 4) < 3)
            return $urandom_range(0, 4095);
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    initial
    begin
        int cfg_cols[4] = '{-4096, 4095, -4096, 2048};
        int cfg_rows[4] = '{-4096, -4096, 4095, 2048};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset center at the origin: center, exact radius, just outside, far corners
        push_pixel(0, 0, 65535);
        push_pixel(0, 0, 0);
        push_pixel(200, 0, 65535);
        push_pixel(120, 160, 65535);
        push_pixel(200, 1, 65535);
        push_pixel(141, 141, 65535);
        push_pixel(141, 142, 65535);
        push_pixel(100, 0, 65535);
        push_pixel(0, 100, 40000);
        push_pixel(1, 1, 65535);
        push_pixel(4095, 4095, 65535);
        push_pixel(4095, 0, 1);
        push_pixel(0, 4095, 65535);
        wait_drained();

        // Center outside the image: true distances, no wrap
        write_center(-100, -50);
        push_pixel(20, 110, 65535);
        push_pixel(20, 111, 65535);
        push_pixel(0, 0, 65535);
        push_pixel(0, 0, 1);
        push_pixel(100, 0, 65535);
        wait_drained();

        // Center at the top corner of the register range
        write_center(4095, 4095);
        push_pixel(4095, 4095, 65535);
        push_pixel(4095, 3895, 65535);
        push_pixel(3955, 3955, 43981);
        wait_drained();

        // Random phases: extreme centers first, then random ones
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p < 4)
                write_center(cfg_cols[p], cfg_rows[p]);
            else
                write_center(pick_center(), pick_center());
            for (int i = 0; i < PHASE_BEATS; i++)
                push_random_pixel();
            if (p == 3)
            begin
                // Hold the sender mid-phase until the pipeline has fully drained
                while (pixel_pending.size() > PHASE_BEATS / 2)
                    @(negedge clk);
                @(posedge clk);
                hold_sender <= 1'b1;
                @(negedge clk);
                while (in_valid || luma_expected.size() != 0)
                    @(negedge clk);
                @(posedge clk);
                hold_sender <= 1'b0;
                @(negedge clk);
            end
            wait_drained();
        end

        repeat (2 * LATENCY) @(negedge clk);
        if (luma_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", luma_expected.size()));
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* radial_spotlight_luma.f */
+incdir+hw/rtl
hw/rtl/rsl_pkg.sv
hw/rtl/rsl_sqrt_cell.sv
hw/rtl/rsl_scale.sv
hw/rtl/rsl_out_buf.sv
hw/rtl/radial_spotlight_luma.sv
verif/radial_spotlight_luma_test.sv
